[hw/rtl/wpd_pkg.sv]
package wpd_pkg;

  localparam int unsigned MaxRowsDefault = 4096;

  localparam logic [1:0] ModeAbs  = 2'd0;
  localparam logic [1:0] ModeEucl = 2'd1;
  localparam logic [1:0] ModeSqrt = 2'd2;

  // Operation requested from the shared iterative unit
  typedef enum logic [1:0] {
    OP_DIV  = 2'd0,
    OP_SQRT = 2'd1
  } iter_op_t;

  typedef struct packed {
    logic     start;
    iter_op_t op;
  } iter_ctl_t;

endpackage

[hw/rtl/wpd_iter_unit.sv]
// Shared restoring unit: 80-bit dividend / 64-bit divisor (one quotient bit
// per cycle), or 80-bit integer square root (one root bit per cycle).
module wpd_iter_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  wpd_pkg::iter_ctl_t  ctl,
  input  logic [79:0]         opa,
  input  logic [63:0]         opb,
  output logic                done,
  output logic [79:0]         result
);
  import wpd_pkg::*;

  logic        busy_r, busy_nxt;
  iter_op_t    op_r, op_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [79:0] num_r, num_nxt;
  logic [63:0] den_r, den_nxt;
  logic [81:0] rem_r, rem_nxt;
  logic [79:0] res_r, res_nxt;
  logic        done_r, done_nxt;

  logic [81:0] shl;
  logic [81:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    done_nxt = 1'b0;
    shl      = '0;
    trial    = '0;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      op_nxt   = ctl.op;
      num_nxt  = opa;
      den_nxt  = opb;
      rem_nxt  = '0;
      res_nxt  = '0;
      cnt_nxt  = (ctl.op == OP_SQRT) ? 7'd40 : 7'd80;
    end else if (busy_r) begin
      case (op_r)
        OP_SQRT: begin
          shl   = {rem_r[79:0], num_r[79:78]};
          trial = {res_r[79:0], 2'b01};
          num_nxt = {num_r[77:0], 2'b00};
        end
        default: begin
          shl   = {rem_r[80:0], num_r[79]};
          trial = {18'd0, den_r};
          num_nxt = {num_r[78:0], 1'b0};
        end
      endcase
      if (shl >= trial) begin
        rem_nxt = shl - trial;
        res_nxt = {res_r[78:0], 1'b1};
      end else begin
        rem_nxt = shl;
        res_nxt = {res_r[78:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= OP_DIV;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    res_r <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

[hw/rtl/weighted_pairwise_distance_unit.sv]
// Weighted pairwise distance, one row per transfer.
// Each row after the transfer runs the weight divide (skipped with a zero weight),
// plus a square root in sqrt mode; the last row then adds the final root (euclidean
// mode only) and the divide by count before out_valid.
// Rows are taken one at a time; the shared divide/sqrt unit sets the pace.
// Reset (rst_n, synchronous, active low) clears the total, count, flag, mode.
module weighted_pairwise_distance_unit #(
  parameter int unsigned MAX_ROWS = wpd_pkg::MaxRowsDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_metric_mode,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] in_value_a,
  input  logic signed [23:0] in_value_b,
  input  logic [31:0]        in_weight_a,
  input  logic [31:0]        in_weight_b,
  input  logic               in_last_row,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [47:0]        out_distance,
  output logic [12:0]        out_rows_used,
  output logic               out_saturated
);
  import wpd_pkg::*;

  localparam int CntW = $clog2(MAX_ROWS + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PROD  = 9'b000000010,
    S_CW    = 9'b000000100,
    S_TERM  = 9'b000001000,
    S_MUL   = 9'b000010000,
    S_ACC   = 9'b000100000,
    S_FROOT = 9'b001000000,
    S_FDIV  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [1:0]  mode_r;
  logic [63:0] total_r, total_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic        ovf_r, ovf_nxt;
  logic        wait_r, wait_nxt;

  logic [24:0] d_r, d_nxt;
  logic [31:0] wa_r, wa_nxt, wb_r, wb_nxt;
  logic        last_r, last_nxt;
  logic [31:0] cw_r, cw_nxt;
  logic [31:0] term_r, term_nxt;
  logic [63:0] sval_r, sval_nxt;
  logic [47:0] dist_r, dist_nxt;
  logic [12:0] rows_r, rows_nxt;
  logic        sat_r, sat_nxt;

  iter_ctl_t   ctl;
  logic [79:0] opa;
  logic [63:0] opb;
  logic        u_done;
  logic [79:0] u_res;

  logic signed [24:0] diff;
  logic [63:0] wt_full;
  logic [64:0] sum;
  logic [CntW-1:0] n;

  wpd_iter_unit u_iter (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .opa(opa), .opb(opb),
    .done(u_done), .result(u_res)
  );

  // term < 2^32 and cw < 2^32, so the product fits 64 bits
  assign diff    = 25'(in_value_a) - 25'(in_value_b);
  assign wt_full = 64'(term_r) * 64'(cw_r);
  assign sum     = {1'b0, total_r} + {1'b0, sval_r};
  assign n       = (cnt_r == '0) ? CntW'(1) : cnt_r;

  always_comb begin
    state_nxt = state_r;
    total_nxt = total_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    wait_nxt  = 1'b0;
    d_nxt = d_r; wa_nxt = wa_r; wb_nxt = wb_r; last_nxt = last_r;
    cw_nxt = cw_r; term_nxt = term_r;
    sval_nxt = sval_r;
    dist_nxt = dist_r; rows_nxt = rows_r; sat_nxt = sat_r;
    ctl.start = 1'b0;
    ctl.op    = OP_DIV;
    opa = '0;
    opb = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          d_nxt    = diff[24] ? 25'(-diff) : 25'(diff);
          wa_nxt   = in_weight_a;
          wb_nxt   = in_weight_b;
          last_nxt = in_last_row;
          if (32'(cnt_r) >= 32'(MAX_ROWS)) begin
            ovf_nxt   = 1'b1;
            state_nxt = in_last_row ? S_FROOT : S_IDLE;
          end else begin
            state_nxt = S_PROD;
          end
        end
      end
      // weight product (one 32x32 multiply) divided by the weight sum; zero if either weight is zero
      S_PROD: begin
        if (wa_r == '0 || wb_r == '0) begin
          cw_nxt    = '0;
          state_nxt = S_TERM;
        end else begin
          ctl.start = 1'b1;
          ctl.op    = OP_DIV;
          opa       = 80'(64'(wa_r) * 64'(wb_r));
          opb       = 64'(33'(wa_r) + 33'(wb_r));
          state_nxt = S_CW;
        end
      end
      S_CW: begin
        if (u_done) begin
          cw_nxt    = u_res[31:0];
          state_nxt = S_TERM;
        end
      end
      // per-row term; sqrt mode runs the shared unit
      S_TERM: begin
        if (!wait_r) begin
          case (mode_r)
            ModeEucl: begin
              term_nxt  = 32'((50'(d_r) * 50'(d_r)) >> 16);
              state_nxt = S_MUL;
            end
            ModeSqrt: begin
              ctl.start = 1'b1;
              ctl.op    = OP_SQRT;
              opa       = 80'({d_r, 16'd0});
              wait_nxt  = 1'b1;
            end
            default: begin
              term_nxt  = 32'(d_r);
              state_nxt = S_MUL;
            end
          endcase
        end else if (u_done) begin
          term_nxt  = u_res[31:0];
          state_nxt = S_MUL;
        end else begin
          wait_nxt = 1'b1;
        end
      end
      S_MUL: begin
        sval_nxt  = 64'(wt_full[63:16]);
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (sum[64]) begin
          total_nxt = '1;
          ovf_nxt   = 1'b1;
        end else begin
          total_nxt = sum[63:0];
        end
        cnt_nxt   = cnt_r + CntW'(1);
        state_nxt = last_r ? S_FROOT : S_IDLE;
      end
      // final root (euclidean) then divide by row count
      S_FROOT: begin
        if (!wait_r) begin
          if (mode_r == ModeEucl) begin
            ctl.start = 1'b1;
            ctl.op    = OP_SQRT;
            opa       = {total_r, 16'd0};
            wait_nxt  = 1'b1;
          end else begin
            sval_nxt  = total_r;
            state_nxt = S_FDIV;
          end
        end else if (u_done) begin
          sval_nxt  = u_res[63:0];
          state_nxt = S_FDIV;
        end else begin
          wait_nxt = 1'b1;
        end
      end
      S_FDIV: begin
        if (!wait_r) begin
          ctl.start = 1'b1;
          ctl.op    = OP_DIV;
          opa       = 80'(sval_r);
          opb       = 64'(n);
          wait_nxt  = 1'b1;
        end else if (u_done) begin
          if (|u_res[79:48]) begin
            dist_nxt = '1;
            sat_nxt  = 1'b1;
          end else begin
            dist_nxt = u_res[47:0];
            sat_nxt  = ovf_r;
          end
          rows_nxt  = 13'(cnt_r);
          total_nxt = '0;
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_OUT;
        end else begin
          wait_nxt = 1'b1;
        end
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= ModeAbs;
      total_r <= '0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      wait_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) mode_r <= cfg_metric_mode;
      total_r <= total_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      wait_r  <= wait_nxt;
    end
    d_r <= d_nxt; wa_r <= wa_nxt; wb_r <= wb_nxt; last_r <= last_nxt;
    cw_r <= cw_nxt; term_r <= term_nxt;
    sval_r <= sval_nxt;
    dist_r <= dist_nxt; rows_r <= rows_nxt; sat_r <= sat_nxt;
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = (state_r == S_OUT);
  assign out_distance  = dist_r;
  assign out_rows_used = rows_r;
  assign out_saturated = sat_r;

endmodule

[tb/sv/wpd_checker.sv]
`timescale 1ns / 1ps

// Watches the config port and both channels, predicts each pair distance and
// compares every result transfer against the oldest prediction.
module wpd_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_metric_mode,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [23:0] in_value_a,
  input  logic signed [23:0] in_value_b,
  input  logic [31:0]        in_weight_a,
  input  logic [31:0]        in_weight_b,
  input  logic               in_last_row,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [47:0]        out_distance,
  input  logic [12:0]        out_rows_used,
  input  logic               out_saturated,
  output int                 error_count,
  output int                 pending_count,
  output int                 rows_seen,
  output int                 results_seen
);
  import wpd_pkg::*;

  localparam logic [47:0] DistMax = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    logic [47:0] distance;
    logic [12:0] rows_used;
    logic        saturated;
  } pair_result_t;

  pair_result_t expected_pairs[$];

  // Shadow copy of the block state and mode
  logic [1:0]  mode_shadow;
  logic [63:0] acc_total;
  logic [12:0] acc_rows;
  logic        acc_clipped;

  // Bit-serial integer square root of an 80-bit operand
  function automatic logic [63:0] int_sqrt80(input logic [79:0] x);
    logic [81:0] rem;
    logic [81:0] trial;
    logic [63:0] root;
    rem  = '0;
    root = '0;
    for (int i = 39; i >= 0; i--) begin
      rem   = (rem << 2) | 82'(x[2*i +: 2]);
      trial = {16'b0, root, 2'b01};
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // Fold one row into the shadow total; returns 1 with a result on the last row
  function automatic bit accumulate_row(input logic signed [23:0] va,
                                        input logic signed [23:0] vb,
                                        input logic [31:0] wa, input logic [31:0] wb,
                                        input logic last, output pair_result_t res);
    longint      diff;
    logic [63:0] d, cw, term, wt, s, n, quot;
    if (acc_rows >= 13'(MaxRowsDefault)) begin
      acc_clipped = 1'b1;
    end else begin
      diff = longint'(va) - longint'(vb);
      d    = (diff < 0) ? 64'(-diff) : 64'(diff);
      cw   = '0;
      if (wa != 0 && wb != 0)
        cw = ({32'b0, wa} * {32'b0, wb}) / ({32'b0, wa} + {32'b0, wb});
      if (mode_shadow == ModeEucl)
        term = (d * d) >> 16;
      else if (mode_shadow == ModeSqrt)
        term = int_sqrt80({16'b0, d << 16});
      else
        term = d;
      wt = (term * cw) >> 16;
      if (acc_total > ~64'd0 - wt) begin
        acc_total   = ~64'd0;
        acc_clipped = 1'b1;
      end else begin
        acc_total = acc_total + wt;
      end
      acc_rows = acc_rows + 13'd1;
    end
    if (!last)
      return 1'b0;
    n = (acc_rows != 0) ? 64'(acc_rows) : 64'd1;
    s = (mode_shadow == ModeEucl) ? int_sqrt80({acc_total, 16'b0}) : acc_total;
    quot = s / n;
    if (quot > 64'(DistMax)) begin
      quot        = 64'(DistMax);
      acc_clipped = 1'b1;
    end
    res.distance  = quot[47:0];
    res.rows_used = acc_rows;
    res.saturated = acc_clipped;
    acc_total   = '0;
    acc_rows    = '0;
    acc_clipped = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  initial begin
    error_count   = 0;
    pending_count = 0;
    rows_seen     = 0;
    results_seen  = 0;
    mode_shadow   = ModeAbs;
    acc_total     = '0;
    acc_rows      = '0;
    acc_clipped   = 1'b0;
  end

  always @(posedge clk) begin
    pair_result_t got, want;
    if (!rst_n) begin
      mode_shadow = ModeAbs;
      acc_total   = '0;
      acc_rows    = '0;
      acc_clipped = 1'b0;
      expected_pairs.delete();
    end else begin
      // Result transfer
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_pairs.size() == 0) begin
          report_mismatch("predictions pending at result transfer", 0, 1);
        end else begin
          want = expected_pairs.pop_front();
          if (out_distance !== want.distance)
            report_mismatch("distance", longint'(out_distance), longint'(want.distance));
          if (out_rows_used !== want.rows_used)
            report_mismatch("rows_used", longint'(out_rows_used), longint'(want.rows_used));
          if (out_saturated !== want.saturated)
            report_mismatch("saturated", longint'(out_saturated), longint'(want.saturated));
        end
      end
      // Row transfer
      if (in_valid && in_ready) begin
        rows_seen++;
        if (accumulate_row(in_value_a, in_value_b, in_weight_a, in_weight_b,
                           in_last_row, got))
          expected_pairs.push_back(got);
      end
      if (cfg_we)
        mode_shadow = cfg_metric_mode;
    end
    pending_count = expected_pairs.size();
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import wpd_pkg::*;

  localparam logic [1:0] ModeUnused = 2'd3;
  localparam int         QuietLimit = 5000;
  localparam int         SettleCycles = 300;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [1:0]         cfg_metric_mode;
  logic               in_valid;
  logic               in_ready;
  logic signed [23:0] in_value_a;
  logic signed [23:0] in_value_b;
  logic [31:0]        in_weight_a;
  logic [31:0]        in_weight_b;
  logic               in_last_row;
  logic               out_valid;
  logic               out_ready;
  logic [47:0]        out_distance;
  logic [12:0]        out_rows_used;
  logic               out_saturated;

  int error_count, pending_count, rows_seen, results_seen;
  int send_idle_pct, recv_idle_pct;
  int quiet_cycles;

  weighted_pairwise_distance_unit dut (
    .clk, .rst_n, .cfg_we, .cfg_metric_mode,
    .in_valid, .in_ready, .in_value_a, .in_value_b, .in_weight_a, .in_weight_b,
    .in_last_row, .out_valid, .out_ready, .out_distance, .out_rows_used, .out_saturated
  );

  wpd_checker u_checker (
    .clk, .rst_n, .cfg_we, .cfg_metric_mode,
    .in_valid, .in_ready, .in_value_a, .in_value_b, .in_weight_a, .in_weight_b,
    .in_last_row, .out_valid, .out_ready, .out_distance, .out_rows_used, .out_saturated,
    .error_count, .pending_count, .rows_seen, .results_seen
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("Watchdog expired after %0d quiet cycles", QuietLimit);
      $display("Test completed with failures");
      $finish;
    end
  end

  // One row transfer; called and returns at a falling edge
  task automatic send_row(input logic [23:0] va, input logic [23:0] vb,
                          input logic [31:0] wa, input logic [31:0] wb, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_value_a  <= va;
    in_value_b  <= vb;
    in_weight_a <= wa;
    in_weight_b <= wb;
    in_last_row <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Wait for all results plus the block's own drain time
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic set_mode(input logic [1:0] m);
    wait_idle();
    cfg_we          <= 1'b1;
    cfg_metric_mode <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [23:0] pick_value();
    case ($urandom_range(7))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'h000000;
      3: return 24'($urandom_range(255)) - 24'd128;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(3)) << 16;
      3: return 32'($urandom_range(65535));
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random_pairs(input int n_rows);
    int sent, len;
    logic [1:0] m;
    sent = 0;
    while (sent < n_rows) begin
      if ($urandom_range(3) == 0) begin
        m = 2'($urandom_range(3));
        set_mode(m);
      end
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      for (int r = 0; r < len; r++)
        send_row(pick_value(), pick_value(), pick_weight(), pick_weight(), r == len - 1);
      sent += len;
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_metric_mode = ModeAbs;
    in_valid        = 1'b0;
    in_value_a      = '0;
    in_value_b      = '0;
    in_weight_a     = '0;
    in_weight_b     = '0;
    in_last_row     = 1'b0;
    out_ready       = 1'b0;
    quiet_cycles    = 0;
    send_idle_pct   = 15;
    recv_idle_pct   = 47;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes in the reset mode
    send_row(24'h7FFFFF, 24'h800000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_row(24'h800000, 24'h7FFFFF, 32'h0001_0000, 32'h0001_0000, 1'b1);
    // zero weight on either side
    send_row(24'h7FFFFF, 24'h000000, 32'h0, 32'hFFFF_FFFF, 1'b0);
    send_row(24'h7FFFFF, 24'h000000, 32'hFFFF_FFFF, 32'h0, 1'b1);
    send_row(24'h123456, 24'h123456, 32'h0002_0000, 32'h0003_0000, 1'b1);
    // euclidean
    set_mode(ModeEucl);
    send_row(24'h7FFFFF, 24'h800000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_row(24'h800000, 24'h7FFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_row(24'h010000, 24'h000000, 32'h0001_0000, 32'h0001_0000, 1'b1);
    // square-root distance
    set_mode(ModeSqrt);
    send_row(24'h7FFFFF, 24'h800000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_row(24'h000001, 24'h000000, 32'h0000_0001, 32'h0000_0001, 1'b1);
    // unused mode behaves as absolute
    set_mode(ModeUnused);
    send_row(24'h400000, 24'hC00000, 32'h8000_0000, 32'h0000_8000, 1'b1);
    // mode change in the middle of a pair
    set_mode(ModeAbs);
    send_row(24'h050000, 24'h010000, 32'h0004_0000, 32'h0004_0000, 1'b0);
    set_mode(ModeEucl);
    send_row(24'h020000, 24'h7F0000, 32'h0001_0000, 32'h0002_0000, 1'b0);
    set_mode(ModeSqrt);
    send_row(24'h7FFFFF, 24'h7FFFFE, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1);

    // Random phase 1: sender idles 15%, receiver 47%
    run_random_pairs(440);
    // Random phase 2: roles swapped
    send_idle_pct = 47;
    recv_idle_pct = 15;
    run_random_pairs(440);
    // Random phase 3: no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_pairs(440);

    wait_idle();
    $display("Covered %0d row transfers and %0d checked results across all modes,",
             rows_seen, results_seen);
    $display("mid-pair mode changes and three back-pressure phases.");
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/wpd_pkg.sv
hw/rtl/wpd_iter_unit.sv
hw/rtl/weighted_pairwise_distance_unit.sv
tb/sv/wpd_checker.sv
tb/sv/tb_top.sv
